// File: rtl/rpl_pkg.sv
package rpl_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESC     = 2'd1,
    MODE_SET     = 2'd2,
    MODE_SET_ESC = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_CLASS  = 2'd1,
    KIND_OP     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    LVL_LOW    = 2'd0,
    LVL_UNION  = 2'd1,
    LVL_KLEENE = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ESC_END  = 2'd1,
    ERR_OPEN_SET = 2'd2
  } lex_err_e;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_PIPE      = 8'h7C;
  localparam logic [7:0] CH_QUEST     = 8'h3F;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_GT        = 8'h3E;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tbyte;
    level_e     level;
    logic       starts;
    lex_err_e   err;
    logic       done;
  } token_t;

  // Letters that name a character class after a backslash.
  function automatic logic is_class_letter(input logic [7:0] c);
    logic hit;
    begin
      case (c)
        "d", "D", "l", "u", "v", "h", "n", "N", "r", "t", "a", "b", "e",
        "f", "k", "x", "X", "w", "W", "s", "S", "R", "0", "E", "Q": hit = 1'b1;
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

endpackage

// File: rtl/rpl_decode.sv
module rpl_decode (
  input  rpl_pkg::mode_e  mode_i,
  input  logic [7:0]      pattern_byte_i,
  input  logic            is_final_i,
  output rpl_pkg::mode_e  mode_next_o,
  output logic            emit_o,
  output rpl_pkg::token_t token_o
);
  import rpl_pkg::*;

  function automatic token_t make_token(input kind_e k, input logic [7:0] c,
                                        input level_e lv, input logic st);
    token_t t;
    begin
      t.kind   = k;
      t.tbyte  = c;
      t.level  = lv;
      t.starts = st;
      t.err    = ERR_NONE;
      t.done   = 1'b0;
      return t;
    end
  endfunction

  function automatic token_t normal_token(input logic [7:0] c);
    token_t t;
    begin
      case (c)
        CH_LBRACKET: t = make_token(KIND_OP, c, LVL_UNION, 1'b1);
        CH_CARET, CH_DOLLAR, CH_LPAREN: t = make_token(KIND_OP, c, LVL_LOW, 1'b1);
        CH_LBRACE, CH_RPAREN, CH_GT, CH_RBRACKET, CH_RBRACE, CH_COMMA, CH_LT: begin
          t = make_token(KIND_OP, c, LVL_LOW, 1'b0);
        end
        CH_PIPE, CH_QUEST: t = make_token(KIND_OP, c, LVL_UNION, 1'b0);
        CH_STAR, CH_PLUS: t = make_token(KIND_OP, c, LVL_KLEENE, 1'b0);
        default: t = make_token(KIND_SYMBOL, c, LVL_LOW, 1'b1);
      endcase
      return t;
    end
  endfunction

  mode_e  nxt;
  token_t tok;
  logic   esc_pending;

  always_comb begin
    tok = make_token(KIND_SYMBOL, pattern_byte_i, LVL_LOW, 1'b1);
    nxt = mode_i;
    case (mode_i)
      MODE_NORMAL: begin
        if (pattern_byte_i == CH_BACKSLASH) begin
          nxt = MODE_ESC;
        end else begin
          tok = normal_token(pattern_byte_i);
          nxt = (pattern_byte_i == CH_LBRACKET) ? MODE_SET : MODE_NORMAL;
        end
      end
      MODE_SET: begin
        if (pattern_byte_i == CH_BACKSLASH) begin
          nxt = MODE_SET_ESC;
        end else if (pattern_byte_i == CH_RBRACKET) begin
          tok = normal_token(pattern_byte_i);
          nxt = MODE_NORMAL;
        end else if (pattern_byte_i == CH_DASH) begin
          tok = make_token(KIND_OP, pattern_byte_i, LVL_LOW, 1'b0);
        end else if (pattern_byte_i == CH_CARET) begin
          tok = make_token(KIND_OP, pattern_byte_i, LVL_LOW, 1'b1);
        end
      end
      default: begin
        if (is_class_letter(pattern_byte_i)) begin
          tok = make_token(KIND_CLASS, pattern_byte_i, LVL_UNION, 1'b1);
        end
        nxt = (mode_i == MODE_SET_ESC) ? MODE_SET : MODE_NORMAL;
      end
    endcase

    esc_pending = (nxt == MODE_ESC) || (nxt == MODE_SET_ESC);

    if (!is_final_i) begin
      emit_o      = !esc_pending;
      mode_next_o = nxt;
      token_o     = tok;
    end else begin
      // The last byte always yields one item and resets the mode for the next pattern.
      emit_o      = 1'b1;
      mode_next_o = MODE_NORMAL;
      token_o     = tok;
      if (esc_pending) begin
        token_o     = make_token(KIND_SYMBOL, 8'h00, LVL_LOW, 1'b0);
        token_o.err = ERR_ESC_END;
      end else if (nxt == MODE_SET) begin
        token_o     = make_token(KIND_SYMBOL, 8'h00, LVL_LOW, 1'b0);
        token_o.err = ERR_OPEN_SET;
      end
      token_o.done = 1'b1;
    end
  end

endmodule

// File: rtl/regex_pattern_lexer_unit.sv
// An accepted item passes the input register, then the result register, to the outputs;
// a backslash opening an escape, if not the last byte, gives no item. Throughput: one item
// per cycle while the output is not stalled; the mode register is read and written by the
// single decode between the two registers, so no byte waits on another.
// Reset (rst_ni low, asynchronous) empties both registers and sets normal mode.
module regex_pattern_lexer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pattern_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic [1:0] binding_level_o,
  output logic       starts_operand_o,
  output logic [1:0] lex_error_o,
  output logic       pattern_done_o
);
  import rpl_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_final_q;
  mode_e      mode_q;
  mode_e      mode_d;
  logic       out_valid_q;
  token_t     out_tok_q;
  token_t     tok;
  logic       emit;
  logic       out_free;
  logic       s1_go;
  logic       in_accept;

  rpl_decode u_decode (
    .mode_i        (mode_q),
    .pattern_byte_i(s1_byte_q),
    .is_final_i    (s1_final_q),
    .mode_next_o   (mode_d),
    .emit_o        (emit),
    .token_o       (tok)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mode_q      <= MODE_NORMAL;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        mode_q <= mode_d;
      end
      if (s1_go && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= pattern_byte_i;
      s1_final_q <= is_final_i;
    end
    if (s1_go && emit) begin
      out_tok_q <= tok;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign token_kind_o     = out_tok_q.kind;
  assign token_byte_o     = out_tok_q.tbyte;
  assign binding_level_o  = out_tok_q.level;
  assign starts_operand_o = out_tok_q.starts;
  assign lex_error_o      = out_tok_q.err;
  assign pattern_done_o   = out_tok_q.done;

endmodule

// File: tb/tb.sv
module tb;
  import rpl_pkg::*;

  localparam string CLASS_LETTERS = "dDluvhnNrtabefkxXwWsSR0EQ";
  localparam logic [7:0] OP_CHARS [14] = '{CH_CARET, CH_DOLLAR, CH_LPAREN, CH_LBRACE,
                                           CH_RPAREN, CH_GT, CH_RBRACKET, CH_RBRACE,
                                           CH_COMMA, CH_LT, CH_PIPE, CH_QUEST, CH_STAR,
                                           CH_PLUS};
  localparam int RANDOM_ITEMS = 550;

  class token_scoreboard;
    mode_e  mode;
    token_t token_q[$];
    int     errors;

    function new();
      mode = MODE_NORMAL;
      errors = 0;
    endfunction

    function automatic logic names_class(logic [7:0] c);
      for (int i = 0; i < CLASS_LETTERS.len(); i++) begin
        if (CLASS_LETTERS[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    function automatic token_t make_token(kind_e k, logic [7:0] c, level_e l, logic s);
      token_t t;
      t.kind   = k;
      t.tbyte  = c;
      t.level  = l;
      t.starts = s;
      t.err    = ERR_NONE;
      t.done   = 1'b0;
      return t;
    endfunction

    function automatic token_t outside_set_token(logic [7:0] c);
      token_t t;
      case (c)
        CH_LBRACKET:                     t = make_token(KIND_OP, c, LVL_UNION, 1'b1);
        CH_CARET, CH_DOLLAR, CH_LPAREN:  t = make_token(KIND_OP, c, LVL_LOW, 1'b1);
        CH_LBRACE, CH_RPAREN, CH_GT, CH_RBRACKET, CH_RBRACE, CH_COMMA, CH_LT:
                                         t = make_token(KIND_OP, c, LVL_LOW, 1'b0);
        CH_PIPE, CH_QUEST:               t = make_token(KIND_OP, c, LVL_UNION, 1'b0);
        CH_STAR, CH_PLUS:                t = make_token(KIND_OP, c, LVL_KLEENE, 1'b0);
        default:                         t = make_token(KIND_SYMBOL, c, LVL_LOW, 1'b1);
      endcase
      return t;
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      token_t t;
      mode_e  nxt;
      logic   emit;
      t = make_token(KIND_SYMBOL, c, LVL_LOW, 1'b1);
      emit = 1'b1;
      nxt = mode;
      case (mode)
        MODE_NORMAL: begin
          if (c == CH_BACKSLASH) begin
            emit = 1'b0;
            nxt = MODE_ESC;
          end else begin
            t = outside_set_token(c);
            nxt = (c == CH_LBRACKET) ? MODE_SET : MODE_NORMAL;
          end
        end
        MODE_SET: begin
          if (c == CH_BACKSLASH) begin
            emit = 1'b0;
            nxt = MODE_SET_ESC;
          end else if (c == CH_RBRACKET) begin
            t = outside_set_token(c);
            nxt = MODE_NORMAL;
          end else if (c == CH_DASH) begin
            t = make_token(KIND_OP, c, LVL_LOW, 1'b0);
          end else if (c == CH_CARET) begin
            t = make_token(KIND_OP, c, LVL_LOW, 1'b1);
          end
        end
        default: begin
          if (names_class(c)) t = make_token(KIND_CLASS, c, LVL_UNION, 1'b1);
          nxt = (mode == MODE_SET_ESC) ? MODE_SET : MODE_NORMAL;
        end
      endcase
      if (last) begin
        // The pattern ends here: an open escape or set turns the token into an error.
        if (nxt == MODE_ESC || nxt == MODE_SET_ESC) begin
          t = make_token(KIND_SYMBOL, 8'h00, LVL_LOW, 1'b0);
          t.err = ERR_ESC_END;
        end else if (nxt == MODE_SET) begin
          t = make_token(KIND_SYMBOL, 8'h00, LVL_LOW, 1'b0);
          t.err = ERR_OPEN_SET;
        end
        t.done = 1'b1;
        emit = 1'b1;
        mode = MODE_NORMAL;
      end else begin
        mode = nxt;
      end
      if (emit) token_q.push_back(t);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (token_q.size() == 0) begin
        $display("%0t: token expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = token_q.pop_front();
      compare_field("token_kind", 8'(want.kind), 8'(got.kind));
      compare_field("token_byte", want.tbyte, got.tbyte);
      compare_field("binding_level", 8'(want.level), 8'(got.level));
      compare_field("starts_operand", 8'(want.starts), 8'(got.starts));
      compare_field("lex_error", 8'(want.err), 8'(got.err));
      compare_field("pattern_done", 8'(want.done), 8'(got.done));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] pattern_byte_i = 8'h00;
  logic       is_final_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] token_kind_o;
  logic [7:0] token_byte_o;
  logic [1:0] binding_level_o;
  logic       starts_operand_o;
  logic [1:0] lex_error_o;
  logic       pattern_done_o;

  token_scoreboard sb;
  int   items_sent = 0;
  logic calm = 1'b0;

  regex_pattern_lexer_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pattern_byte_i(pattern_byte_i),
    .is_final_i(is_final_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .token_kind_o(token_kind_o),
    .token_byte_o(token_byte_o),
    .binding_level_o(binding_level_o),
    .starts_operand_o(starts_operand_o),
    .lex_error_o(lex_error_o),
    .pattern_done_o(pattern_done_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then a long one, none at all in a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_token({token_kind_o, token_byte_o, binding_level_o, starts_operand_o,
                      lex_error_o, pattern_done_o});
    end
  end

  initial begin
    int free_run;
    int stall_run;
    @(negedge clk_i);
    forever begin
      free_run = 1 + pick_gap();
      out_stall_i <= 1'b0;
      repeat (free_run) @(negedge clk_i);
      stall_run = pick_gap();
      if (stall_run > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_run) @(negedge clk_i);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pattern_byte_i <= c;
    is_final_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(c, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.token_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte(logic [7:0] avoid);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_BACKSLASH || c == avoid) c = 8'h61;
    return c;
  endfunction

  function automatic logic [7:0] escaped_byte();
    if ($urandom_range(0, 1) == 0)
      return CLASS_LETTERS[$urandom_range(0, CLASS_LETTERS.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_pattern();
    logic [7:0] q[$];
    int         pieces;
    int         members;
    pieces = $urandom_range(1, 10);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2: q.push_back(plain_byte(CH_LBRACKET));
        3, 4:    q.push_back(OP_CHARS[$urandom_range(0, 13)]);
        5: begin
          q.push_back(CH_BACKSLASH);
          q.push_back(escaped_byte());
        end
        6, 7: begin
          q.push_back(CH_LBRACKET);
          members = $urandom_range(0, 4);
          repeat (members) begin
            case ($urandom_range(0, 4))
              0:       q.push_back(CH_DASH);
              1:       q.push_back(CH_CARET);
              2: begin
                q.push_back(CH_BACKSLASH);
                q.push_back(escaped_byte());
              end
              default: q.push_back(plain_byte(CH_RBRACKET));
            endcase
          end
          // Now and then the set is left open.
          if ($urandom_range(0, 7) != 0) q.push_back(CH_RBRACKET);
        end
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 11) == 0) q.push_back(CH_BACKSLASH);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_text("^a$(\\d|\\q)*+?");
    send_text("[^-\\dz]");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\\");
    send_text("[a");
    send_text("[");
    send_text("[\\d");

    while (items_sent < 29 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      if (!paused && items_sent > 29 + RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_tokens();
      end
      send_random_pattern();
    end
    calm = 1'b0;

    drain_tokens();
    if (sb.errors == 0 && sb.token_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rpl_pkg.sv
rtl/rpl_decode.sv
rtl/regex_pattern_lexer_unit.sv
tb/tb.sv
